### design/tce_pkg.sv
`default_nettype none

package tce_pkg;

    // Action codes carried in the input word
    localparam logic [2:0] ACT_PUT    = 3'd0;
    localparam logic [2:0] ACT_MOVE   = 3'd1;
    localparam logic [2:0] ACT_CLEAR  = 3'd2;
    localparam logic [2:0] ACT_SCROLL = 3'd3;
    localparam logic [2:0] ACT_READ   = 3'd4;

    localparam logic [7:0] NULL_CODE    = 8'h00;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_GLYPH  = 8'h20;
    localparam logic [7:0] RESET_COLOR  = 8'hF0;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_code;
        logic [7:0] target_row;
        logic [7:0] target_col;
        logic [7:0] scroll_count;
    } t_tce_in;

    typedef struct packed {
        logic [4:0]  cursor_row_out;
        logic [6:0]  cursor_col_out;
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } t_tce_out;

endpackage

`default_nettype wire

### design/tce_ram.sv
`default_nettype none

module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### design/text_console_engine.sv
`default_nettype none

// Text console engine: a ROWS x COLUMNS character screen held in one
// synchronous RAM of 16-bit cells (color byte high, glyph byte low) and a
// cursor kept in registers. One word in gives one word out with the cursor
// after the action. Path per word, from acceptance to the result being
// loaded into the output register: put char, move cursor, scroll by zero,
// an out-of-range read and unknown actions load the result in the accept
// cycle itself; read cell reads the RAM, captures the cell in S_READ and
// loads it from S_DONE; a put char or newline that runs off the bottom row
// scrolls by one line; scroll by N copies (ROWS-N)*COLUMNS cells through
// the RAM at one cell per cycle and then blanks N*COLUMNS cells; clear
// blanks every cell. The single RAM write port paces these passes. After
// reset the engine runs a clearing pass over all ROWS*COLUMNS cells that
// fills the screen with spaces in color 0xF0, and takes no input word until
// it ends; configuration writes are taken at any time. Input is taken only
// when the output register is empty or being drained in the same cycle.
module text_console_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // input words
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire tce_pkg::t_tce_in i_in_word,
    // result words
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output tce_pkg::t_tce_out     o_out_word,
    // text color register
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [7:0]       i_cfg_data
);

    import tce_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int POS_W  = (ADDR_W > 11) ? ADDR_W : 11;
    localparam int RO_W   = (ROW_W > 5) ? ROW_W : 5;
    localparam int CO_W   = (COL_W > 7) ? COL_W : 7;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_BLANK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [7:0]       r_color;
    logic             r_init, n_init;
    logic [CNT_W-1:0] r_src, n_src;
    logic [CNT_W-1:0] r_dst, n_dst;
    logic             r_rd_pend, n_rd_pend;
    logic [15:0]      r_cell, n_cell;
    logic             r_out_valid;
    t_tce_out         r_out_word;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;

    logic              out_free;
    logic              load_out;
    logic [15:0]       out_cell;
    t_tce_out          out_word;
    logic [ADDR_W-1:0] cur_idx;
    logic [ADDR_W-1:0] tgt_idx;
    logic              row_ok;
    logic              col_ok;
    logic [7:0]        scroll_sat;
    logic [POS_W-1:0]  pos_full;
    logic [RO_W-1:0]   row_ext;
    logic [CO_W-1:0]   col_ext;

    // Output register frees up when empty or drained this cycle
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Cell addresses of the cursor and of the requested target
    assign cur_idx = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign tgt_idx = ADDR_W'(i_in_word.target_row[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                   + ADDR_W'(i_in_word.target_col[COL_W-1:0]);
    assign row_ok  = int'(i_in_word.target_row) < ROWS;
    assign col_ok  = int'(i_in_word.target_col) < COLUMNS;

    // Saturate the scroll count at the screen height
    assign scroll_sat = (int'(i_in_word.scroll_count) > ROWS) ? 8'(ROWS)
                                                              : i_in_word.scroll_count;

    // Result word built from the cursor as it stands after the action
    assign pos_full = POS_W'(n_row) * POS_W'(COLUMNS) + POS_W'(n_col);
    assign row_ext  = RO_W'(n_row);
    assign col_ext  = CO_W'(n_col);

    always_comb begin
        out_word.cursor_row_out  = row_ext[4:0];
        out_word.cursor_col_out  = col_ext[6:0];
        out_word.cursor_position = pos_full[10:0];
        out_word.cell_data       = out_cell;
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_init    = r_init;
        n_src     = r_src;
        n_dst     = r_dst;
        n_rd_pend = r_rd_pend;
        n_cell    = r_cell;
        wr_en     = 1'b0;
        wr_addr   = r_dst[ADDR_W-1:0];
        wr_data   = {r_color, BLANK_GLYPH};
        rd_addr   = r_src[ADDR_W-1:0];
        load_out  = 1'b0;
        out_cell  = r_cell;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid && out_free) begin
                    n_cell   = '0;
                    out_cell = '0;
                    case (i_in_word.action)
                        ACT_PUT: begin
                            if (i_in_word.char_code == NULL_CODE) begin
                                load_out = 1'b1;
                            end else begin
                                // Printable glyph: write at the cursor, then advance; a newline only advances
                                if (i_in_word.char_code != NEWLINE_CODE) begin
                                    wr_en   = 1'b1;
                                    wr_addr = cur_idx;
                                    wr_data = {r_color, i_in_word.char_code};
                                end
                                if (i_in_word.char_code != NEWLINE_CODE &&
                                    r_col != COL_W'(COLUMNS - 1)) begin
                                    n_col    = r_col + COL_W'(1);
                                    load_out = 1'b1;
                                end else begin
                                    n_col = '0;
                                    if (r_row == ROW_W'(ROWS - 1)) begin
                                        // Ran off the bottom: scroll one line
                                        n_src   = CNT_W'(COLUMNS);
                                        n_dst   = '0;
                                        n_state = S_COPY;
                                    end else begin
                                        n_row    = r_row + ROW_W'(1);
                                        load_out = 1'b1;
                                    end
                                end
                            end
                        end
                        ACT_MOVE: begin
                            if (row_ok) begin
                                n_row = i_in_word.target_row[ROW_W-1:0];
                            end
                            if (col_ok) begin
                                n_col = i_in_word.target_col[COL_W-1:0];
                            end
                            load_out = 1'b1;
                        end
                        ACT_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_dst   = '0;
                            n_state = S_BLANK;
                        end
                        ACT_SCROLL: begin
                            if (i_in_word.scroll_count == 8'd0) begin
                                load_out = 1'b1;
                            end else begin
                                n_src   = CNT_W'(scroll_sat) * CNT_W'(COLUMNS);
                                n_dst   = '0;
                                n_state = S_COPY;
                            end
                        end
                        ACT_READ: begin
                            if (row_ok && col_ok) begin
                                rd_addr = tgt_idx;
                                n_state = S_READ;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Capture the cell read in the accept cycle
                n_cell  = rd_data;
                n_state = S_DONE;
            end
            S_COPY: begin
                // Read ahead one cell, write back the cell read last cycle
                if (r_rd_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = r_dst[ADDR_W-1:0];
                    wr_data = rd_data;
                    n_dst   = r_dst + CNT_W'(1);
                end
                if (r_src < CNT_W'(CELLS)) begin
                    rd_addr   = r_src[ADDR_W-1:0];
                    n_src     = r_src + CNT_W'(1);
                    n_rd_pend = 1'b1;
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_state = S_BLANK;
                    end
                end
            end
            S_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = r_dst[ADDR_W-1:0];
                wr_data = r_init ? {RESET_COLOR, BLANK_GLYPH} : {r_color, BLANK_GLYPH};
                n_dst   = r_dst + CNT_W'(1);
                if (r_dst == CNT_W'(CELLS - 1)) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    tce_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // Start with the clearing pass over the whole screen
            r_state     <= S_BLANK;
            r_init      <= 1'b1;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= RESET_COLOR;
            r_src       <= '0;
            r_dst       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_init    <= n_init;
            r_row     <= n_row;
            r_col     <= n_col;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_rd_pend <= n_rd_pend;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the result word holds until the next result loads
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
        if (load_out) begin
            r_out_word <= out_word;
        end
    end

endmodule

`default_nettype wire
